// ===== design/crsd_pkg.sv =====
// Shared types, constants and the preset text lookup of the compressed-RTF decoder.
// No dependencies; all other design files but crsd_ram import this package.
package crsd_pkg;

  // ring geometry and preset
  localparam int RING_SIZE  = 4096;
  localparam int RING_AW    = 12;
  localparam int PRESET_LEN = 207;
  localparam int CMD_DEPTH  = 4;

  // header magic words
  localparam logic [31:0] MAGIC_PLAIN  = 32'h414c454d;
  localparam logic [31:0] MAGIC_PACKED = 32'h75465a4c;

  // command kinds from front to back
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_LIT   = 2'd1;
  localparam logic [1:0] CMD_COPY  = 2'd2;
  localparam logic [1:0] CMD_ERR   = 2'd3;

  // result status codes
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_MAGIC = 1'b1;

  // rtf prefix, first character in the top byte
  localparam logic [PRESET_LEN*8-1:0] PRESET_TEXT = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}{\\f0\\fnil \\froman \\fswiss ",
    "\\fmodern \\fscript \\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
    "{\\colortbl\\red0\\green0\\blue0", 8'h0d, 8'h0a,
    "\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       status;
  } out_item_t;

  // arg: raw size for begin, byte for literal, {pos, len - 2} for copy
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] arg;
  } cmd_t;

  // content of a ring entry that the current stream has not written
  function automatic logic [7:0] preset_byte(input logic [RING_AW-1:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (addr < RING_AW'(PRESET_LEN)) begin
      b = PRESET_TEXT[(PRESET_LEN - 1 - int'(addr)) * 8 +: 8];
    end
    return b;
  endfunction

endpackage

// ===== design/crsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module crsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/crsd_front.sv =====
// Front end: parses header, flag bytes and tokens, emits a command per header, token or plain byte.
// Depends on crsd_pkg.
module crsd_front import crsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_accept,
  input  in_item_t in_data,
  output logic     cmd_push,
  output cmd_t     cmd_data
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_HDR   = 2'd1;
  localparam logic [1:0] MODE_COMP  = 2'd2;
  localparam logic [1:0] MODE_PLAIN = 2'd3;

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_TOK  = 2'd1;
  localparam logic [1:0] PH_REF  = 2'd2;

  logic [1:0]  mode_r, mode_nxt;
  logic [4:0]  hcnt_r, hcnt_nxt;
  logic [63:0] hshift_r, hshift_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  offhi_r, offhi_nxt;

  logic [1:0]  mode_v;
  logic [4:0]  hcnt_v;
  logic [63:0] hshift_v;
  logic [2:0]  fidx_v;
  logic [1:0]  phase_v;
  logic [7:0]  b;

  // token parser
  always_comb begin
    b          = in_data.in_byte;
    mode_v     = in_data.start_req ? MODE_HDR : mode_r;
    hcnt_v     = in_data.start_req ? 5'd0 : hcnt_r;
    hshift_v   = in_data.start_req ? 64'd0 : hshift_r;
    fidx_v     = in_data.start_req ? 3'd0 : fidx_r;
    phase_v    = in_data.start_req ? PH_FLAG : phase_r;
    mode_nxt   = mode_v;
    hcnt_nxt   = hcnt_v;
    hshift_nxt = hshift_v;
    flags_nxt  = in_data.start_req ? 8'd0 : flags_r;
    fidx_nxt   = fidx_v;
    phase_nxt  = phase_v;
    offhi_nxt  = in_data.start_req ? 8'd0 : offhi_r;
    cmd_push   = 1'b0;
    cmd_data   = '{kind: CMD_LIT, arg: {24'd0, b}};
    case (mode_v)
      MODE_HDR: begin
        if (hcnt_v < 5'd12) begin
          hshift_nxt = {b, hshift_v[63:8]};
        end
        hcnt_nxt = hcnt_v + 5'd1;
        if (hcnt_nxt == 5'd16) begin
          fidx_nxt  = 3'd0;
          phase_nxt = PH_FLAG;
          cmd_push  = in_accept;
          if (hshift_nxt[63:32] == MAGIC_PACKED) begin
            mode_nxt = (hshift_nxt[31:0] != 32'd0) ? MODE_COMP : MODE_IDLE;
            cmd_data = '{kind: CMD_BEGIN, arg: hshift_nxt[31:0]};
          end else if (hshift_nxt[63:32] == MAGIC_PLAIN) begin
            mode_nxt = (hshift_nxt[31:0] != 32'd0) ? MODE_PLAIN : MODE_IDLE;
            cmd_data = '{kind: CMD_BEGIN, arg: hshift_nxt[31:0]};
          end else begin
            mode_nxt = MODE_IDLE;
            cmd_data = '{kind: CMD_ERR, arg: 32'd0};
          end
        end
      end
      MODE_COMP: begin
        case (phase_v)
          PH_FLAG: begin
            flags_nxt = b;
            fidx_nxt  = 3'd0;
            phase_nxt = PH_TOK;
          end
          PH_TOK: begin
            if (!flags_r[fidx_v]) begin
              cmd_push  = in_accept;
              fidx_nxt  = fidx_v + 3'd1;
              phase_nxt = (fidx_nxt == 3'd0) ? PH_FLAG : PH_TOK;
            end else begin
              offhi_nxt = b;
              phase_nxt = PH_REF;
            end
          end
          default: begin
            cmd_push  = in_accept;
            cmd_data  = '{kind: CMD_COPY, arg: {16'd0, offhi_r, b}};
            fidx_nxt  = fidx_v + 3'd1;
            phase_nxt = (fidx_nxt == 3'd0) ? PH_FLAG : PH_TOK;
          end
        endcase
      end
      MODE_PLAIN: begin
        cmd_push = in_accept;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      hcnt_r  <= 5'd0;
      fidx_r  <= 3'd0;
      phase_r <= PH_FLAG;
      flags_r <= 8'd0;
      offhi_r <= 8'd0;
    end else if (in_accept) begin
      mode_r  <= mode_nxt;
      hcnt_r  <= hcnt_nxt;
      fidx_r  <= fidx_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      offhi_r <= offhi_nxt;
    end
  end

  // header shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hshift_r <= 64'd0;
    end else if (in_accept) begin
      hshift_r <= hshift_nxt;
    end
  end

endmodule

// ===== design/crsd_cmd_fifo.sv =====
// Command queue between the parsing front end and the executing back end.
// Depends on crsd_pkg.
module crsd_cmd_fifo import crsd_pkg::*; #(
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t        slots_r [DEPTH];
  logic [AW:0] wr_ptr_r;
  logic [AW:0] rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign dout  = slots_r[rd_ptr_r[AW-1:0]];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_ptr_r[AW-1:0]] <= din;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== design/crsd_back.sv =====
// Back end: executes commands through the history ring and drives the output register.
// Depends on crsd_pkg and crsd_ram.
module crsd_back import crsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd_data,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               live_r, live_nxt;
  logic [31:0]        remain_r, remain_nxt;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [RING_AW:0]   fill_r, fill_nxt;
  logic [RING_AW-1:0] pos_r, pos_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               oval_r, oval_nxt;
  out_item_t          odata_r, odata_nxt;

  logic               slot_free;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_last;
  logic               ram_rd_en;
  logic [7:0]         ram_q;
  logic [RING_AW-1:0] rel_pos;
  logic               hist_valid;
  logic [7:0]         hist_byte;

  crsd_ram #(
    .WIDTH (8),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk     (clk),
    .wr_en   (emit),
    .wr_addr (wp_r),
    .wr_data (emit_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (pos_r),
    .rd_data (ram_q)
  );

  // entries not yet written in this stream read as preset text or zero
  assign rel_pos    = pos_r - RING_AW'(PRESET_LEN);
  assign hist_valid = {1'b0, rel_pos} < fill_r;
  assign hist_byte  = hist_valid ? ram_q : preset_byte(pos_r);

  assign slot_free = !oval_r || out_pop;
  assign emit_last = (remain_r == 32'd1);
  assign ram_rd_en = (state_r == ST_RD);

  // command sequencer
  always_comb begin
    state_nxt = state_r;
    live_nxt  = live_r;
    remain_nxt = remain_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_byte = cmd_data.arg[7:0];
    oval_nxt  = oval_r && !out_pop;
    odata_nxt = odata_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_data.kind)
            CMD_BEGIN: begin
              cmd_pop    = 1'b1;
              live_nxt   = (cmd_data.arg != 32'd0);
              remain_nxt = cmd_data.arg;
              wp_nxt     = RING_AW'(PRESET_LEN);
              fill_nxt   = '0;
            end
            CMD_ERR: begin
              if (slot_free) begin
                cmd_pop   = 1'b1;
                live_nxt  = 1'b0;
                oval_nxt  = 1'b1;
                odata_nxt = '{out_byte: 8'd0, last: 1'b1, status: STATUS_MAGIC};
              end
            end
            CMD_LIT: begin
              if (!live_r) begin
                cmd_pop = 1'b1;
              end else if (slot_free) begin
                cmd_pop = 1'b1;
                emit    = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
              if (live_r) begin
                pos_nxt   = cmd_data.arg[15:4];
                cnt_nxt   = {1'b0, cmd_data.arg[3:0]} + 5'd2;
                state_nxt = ST_RD;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      default: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = hist_byte;
          pos_nxt   = pos_r + 1'b1;
          cnt_nxt   = cnt_r - 5'd1;
          state_nxt = (emit_last || cnt_r == 5'd1) ? ST_IDLE : ST_RD;
        end
      end
    endcase
    // shared byte output path
    if (emit) begin
      wp_nxt     = wp_r + 1'b1;
      fill_nxt   = fill_r[RING_AW] ? fill_r : fill_r + 1'b1;
      remain_nxt = remain_r - 32'd1;
      oval_nxt   = 1'b1;
      odata_nxt  = '{out_byte: emit_byte, last: emit_last, status: STATUS_DATA};
      if (emit_last) begin
        live_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      live_r  <= 1'b0;
      wp_r    <= RING_AW'(PRESET_LEN);
      fill_r  <= '0;
      oval_r  <= 1'b0;
      remain_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      oval_r  <= oval_nxt;
      remain_r <= remain_nxt;
    end
  end

  // copy cursor and output payload
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
  end

  assign out_empty = !oval_r;
  assign out_item  = odata_r;

endmodule

// ===== design/compressed_rtf_stream_decoder_top.sv =====
// Compressed-RTF stream decoder: header parse, LZ token expansion over a 4096-byte ring.
// A literal or pass-through byte goes through the command queue and the output register, a
// reference from its second byte through the queue, a ring read and that register.
// Throughput: one item per cycle into the queue while it is not full; the back end ends a
// reference before its next command. Reset: synchronous active-low; no ring clearing pass, a
// fill count marks entries written since stream start, the rest read as preset text or zero.
module compressed_rtf_stream_decoder_top import crsd_pkg::*; #(
  parameter int CMD_QUEUE_DEPTH = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic in_accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;

  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  crsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  crsd_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  crsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for compressed_rtf_stream_decoder_top: headers, packed and plain
// streams, restarts, bad magic and stalls, checked against a built-in decoder model.
// Depends on crsd_pkg (item types, magic words, preset text) and the decoder RTL.
module tb_top;
  import crsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {MODE_IDLE, MODE_HEADER, MODE_PACKED, MODE_PLAIN} stream_mode_e;
  typedef enum logic [1:0] {TOK_FLAGS, TOK_FIRST, TOK_SECOND} token_phase_e;

  // decoder model and queue of expected output bytes
  class rtf_scoreboard;
    logic [7:0]   ring [RING_SIZE];
    logic [11:0]  wr_pos;
    int unsigned  hdr_cnt;
    logic [63:0]  hdr_bits;
    logic [31:0]  bytes_left;
    logic [7:0]   flags;
    logic [2:0]   flag_pos;
    logic [7:0]   pos_hi;
    token_phase_e phase;
    stream_mode_e mode;
    out_item_t    expected_q[$];
    int           n_fail;
    int           n_checked;

    function new();
      restart();
      mode = MODE_IDLE;
      n_fail = 0;
      n_checked = 0;
    endfunction

    // ring preset and cleared parser state at a stream start
    function void restart();
      for (int i = 0; i < RING_SIZE; i++) begin
        ring[i] = (i < PRESET_LEN) ? PRESET_TEXT[(PRESET_LEN - 1 - i) * 8 +: 8] : 8'h00;
      end
      wr_pos     = 12'(PRESET_LEN);
      hdr_cnt    = 0;
      hdr_bits   = '0;
      bytes_left = '0;
      flags      = '0;
      flag_pos   = '0;
      pos_hi     = '0;
      phase      = TOK_FLAGS;
      mode       = MODE_IDLE;
    endfunction

    // one produced byte; returns 0 once the raw size is reached
    function bit emit_byte(logic [7:0] b);
      out_item_t r;
      ring[wr_pos] = b;
      wr_pos++;
      bytes_left--;
      r.out_byte = b;
      r.last     = (bytes_left == 0);
      r.status   = STATUS_DATA;
      expected_q.push_back(r);
      if (r.last) mode = MODE_IDLE;
      return !r.last;
    endfunction

    function void next_token();
      flag_pos++;
      phase = (flag_pos == 0) ? TOK_FLAGS : TOK_FIRST;
    endfunction

    // accepted input item
    function void note_input(in_item_t it);
      logic [7:0]  b;
      logic [11:0] rd;
      logic [31:0] magic;
      int          len;
      bit          live;
      out_item_t   r;
      b = it.in_byte;
      if (it.start_req) begin
        restart();
        mode = MODE_HEADER;
      end
      case (mode)
        MODE_HEADER: begin
          if (hdr_cnt < 12) hdr_bits = {b, hdr_bits[63:8]};
          hdr_cnt++;
          if (hdr_cnt >= 16) begin
            bytes_left = hdr_bits[31:0];
            magic      = hdr_bits[63:32];
            flag_pos   = '0;
            phase      = TOK_FLAGS;
            if (magic == MAGIC_PACKED) begin
              mode = (bytes_left != 0) ? MODE_PACKED : MODE_IDLE;
            end else if (magic == MAGIC_PLAIN) begin
              mode = (bytes_left != 0) ? MODE_PLAIN : MODE_IDLE;
            end else begin
              mode = MODE_IDLE;
              r.out_byte = 8'h00;
              r.last     = 1'b1;
              r.status   = STATUS_MAGIC;
              expected_q.push_back(r);
            end
          end
        end
        MODE_PACKED: begin
          case (phase)
            TOK_FLAGS: begin
              flags    = b;
              flag_pos = '0;
              phase    = TOK_FIRST;
            end
            TOK_FIRST: begin
              if (!flags[flag_pos]) begin
                if (emit_byte(b)) next_token();
              end else begin
                pos_hi = b;
                phase  = TOK_SECOND;
              end
            end
            default: begin
              // back reference, may read bytes it has just written
              rd   = {pos_hi, b[7:4]};
              len  = int'(b[3:0]) + 2;
              live = 1'b1;
              for (int i = 0; i < len && live; i++) begin
                live = emit_byte(ring[rd]);
                rd++;
              end
              if (live) next_token();
            end
          endcase
        end
        MODE_PLAIN: begin
          void'(emit_byte(b));
        end
        default: ;
      endcase
    endfunction

    // accepted output item against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected item: out_byte %02h last %0b status %0b",
               got.out_byte, got.last, got.status);
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
        n_fail++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        n_fail++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, got.status);
        n_fail++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  rtf_scoreboard sb;
  logic [7:0]    stream_q[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_left = 0;
  int            n_items = 0;
  int            n_streams = 0;

  compressed_rtf_stream_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // watchdog
  initial begin
    #10ms;
    $display("FAIL compressed_rtf_stream_decoder_top");
    $finish;
  end

  // output side: check accepted items, random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one input item, held until the decoder takes it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(it);
    n_items++;
  endtask

  task automatic send_stream();
    in_item_t it;
    n_streams++;
    foreach (stream_q[i]) begin
      it.in_byte   = stream_q[i];
      it.start_req = (i == 0);
      send_item(it);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // little-endian word into the stream
  function automatic void add_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) stream_q.push_back(w[k*8 +: 8]);
  endfunction

  // compressed size and checksum are random, the decoder ignores both
  function automatic void add_header(logic [31:0] raw, logic [31:0] magic);
    add_word($urandom);
    add_word(raw);
    add_word(magic);
    add_word($urandom);
  endfunction

  // flag groups with literals and references until about limit bytes are produced
  function automatic void add_tokens(int limit, int ref_pct);
    int          made;
    logic [7:0]  fl;
    logic [11:0] p;
    logic [3:0]  ln;
    made = 0;
    while (made < limit) begin
      for (int k = 0; k < 8; k++) fl[k] = ($urandom_range(99) < ref_pct);
      stream_q.push_back(fl);
      for (int k = 0; k < 8 && made < limit; k++) begin
        if (!fl[k]) begin
          stream_q.push_back(8'($urandom));
          made++;
        end else begin
          ln = 4'($urandom);
          case ($urandom_range(3))
            0: p = 12'(PRESET_LEN + made - int'($urandom_range(1, 40)));
            1: p = 12'(PRESET_LEN + made);
            default: p = 12'($urandom);
          endcase
          stream_q.push_back(p[11:4]);
          stream_q.push_back({p[3:0], ln});
          made += int'(ln) + 2;
        end
      end
    end
  endfunction

  // mostly well-formed packed streams, the rest plain, bad, empty or cut short
  function automatic void build_random_stream();
    int          pick;
    logic [31:0] raw;
    logic [31:0] magic;
    stream_q.delete();
    pick = $urandom_range(99);
    if (pick < 65) begin
      raw = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      add_header(raw, MAGIC_PACKED);
      add_tokens(int'(raw), $urandom_range(10, 90));
    end else if (pick < 80) begin
      raw = $urandom_range(1, 12);
      add_header(raw, MAGIC_PLAIN);
      repeat (raw) stream_q.push_back(8'($urandom));
    end else if (pick < 86) begin
      magic = $urandom;
      if ($urandom_range(1)) begin
        magic = ($urandom_range(1) ? MAGIC_PACKED : MAGIC_PLAIN) ^ (32'h1 << $urandom_range(31));
      end
      if (magic == MAGIC_PACKED || magic == MAGIC_PLAIN) magic = ~magic;
      add_header($urandom, magic);
    end else if (pick < 89) begin
      add_header(32'h0, $urandom_range(1) ? MAGIC_PACKED : MAGIC_PLAIN);
    end else begin
      // huge raw size, abandoned by the next start
      raw = $urandom | 32'h0000_1000;
      if ($urandom_range(1)) begin
        add_header(raw, MAGIC_PACKED);
        add_tokens($urandom_range(4, 30), $urandom_range(10, 90));
      end else begin
        add_header(raw, MAGIC_PLAIN);
        repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom));
      end
    end
    // bytes after the end of the stream
    if (pick < 89) repeat ($urandom_range(0, 2)) stream_q.push_back(8'($urandom));
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    int first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = n_items;
    while (n_items - first < n) begin
      build_random_stream();
      send_stream();
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte while idle
    it.in_byte   = 8'hA5;
    it.start_req = 1'b0;
    send_item(it);

    // near-miss magic
    stream_q.delete();
    add_header(32'd5, MAGIC_PACKED ^ 32'h1);
    send_stream();

    // zero raw size
    stream_q.delete();
    add_header(32'd0, MAGIC_PACKED);
    send_stream();

    // literal 0xff, then longest reference from position 0 cut by raw size, trailing byte
    stream_q.delete();
    add_header(32'd3, MAGIC_PACKED);
    stream_q = {stream_q, 8'h02, 8'hFF, 8'h00, 8'h0F, 8'h00};
    send_stream();

    // top position with shortest length, copy overlapping its own output, cut by restart
    stream_q.delete();
    add_header(32'hFFFF_FFFF, MAGIC_PACKED);
    stream_q = {stream_q, 8'h06, 8'h41, 8'hFF, 8'hF0, 8'h0C, 8'hF4};
    send_stream();

    // plain stream with extreme bytes and a trailing byte
    stream_q.delete();
    add_header(32'd2, MAGIC_PLAIN);
    stream_q = {stream_q, 8'hFF, 8'h00, 8'h5A};
    send_stream();

    // output held off while a reference-heavy stream fills the decoder
    stream_q.delete();
    add_header(32'd150, MAGIC_PACKED);
    add_tokens(150, 60);
    hold_left = 300;
    send_stream();
    push <= 1'b0;
    wait_drained();

    run_phase(0, 0, 30);
    run_phase(74, 0, 30);
    run_phase(0, 74, 30);
    run_phase(12, 12, 30);
    push <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d input items in %0d streams, %0d output items checked",
             n_items, n_streams, sb.n_checked);
    $display("packed, plain, bad-magic, empty and restarted streams under four stall mixes");
    if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
      $display("PASS compressed_rtf_stream_decoder_top");
    end else begin
      $display("FAIL compressed_rtf_stream_decoder_top");
    end
    $finish;
  end

endmodule
